### rtl/core/elevator_group_dispatcher_top_defines.svh
// Assertion macros shared by the dispatcher RTL.
`ifndef ELEVATOR_GROUP_DISPATCHER_TOP_DEFINES_SVH
`define ELEVATOR_GROUP_DISPATCHER_TOP_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define EGD_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("dispatcher invariant violated");

// A condition that must hold in the cycle after a trigger.
`define EGD_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("dispatcher sequence violated");

`endif

### rtl/core/egd_pkg.sv
`timescale 1ns / 1ps

package egd_pkg;

    localparam int CARS     = 6;
    localparam int FLOOR_W  = 5;
    localparam int CAR_W    = 3;
    localparam int TICKET_W = 4;
    localparam int DIST_W   = 7;

    localparam logic [DIST_W-1:0] DIST_INIT = 7'd100;
    localparam logic [3:0]        RIDER_MAX = 4'd15;

    // Request operation codes.
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_CALL   = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_ASSIGNED   = 3'd0;
    localparam logic [2:0] ST_FROM_QUEUE = 3'd1;
    localparam logic [2:0] ST_QUEUED     = 3'd2;
    localparam logic [2:0] ST_DROPPED    = 3'd3;
    localparam logic [2:0] ST_INVALID    = 3'd4;
    localparam logic [2:0] ST_CANCELLED  = 3'd5;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd6;
    localparam logic [2:0] ST_TICK_IDLE  = 3'd7;

    // Stop mark codes.
    localparam logic [1:0] MARK_NONE   = 2'd0;
    localparam logic [1:0] MARK_DEST   = 2'd1;
    localparam logic [1:0] MARK_PICKUP = 2'd2;

    // Car travel direction codes.
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_DOOR_DWELL   = 1'b0;
    localparam logic CFG_LOW_ZONE_TOP = 1'b1;

    // Zone masks, bit i allows car i.
    localparam logic [CARS-1:0] ZONE_LOW   = 6'b110011;
    localparam logic [CARS-1:0] ZONE_HIGH  = 6'b111100;
    localparam logic [CARS-1:0] ZONE_CROSS = 6'b110000;

    typedef struct packed {
        logic [1:0]         op;
        logic [FLOOR_W-1:0] from_floor;
        logic [FLOOR_W-1:0] to_floor;
        logic [CAR_W-1:0]   car;
    } req_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [CAR_W-1:0]    assigned_car;
        logic [TICKET_W-1:0] wait_number;
        logic [FLOOR_W-1:0]  out_from;
        logic [FLOOR_W-1:0]  out_to;
    } rsp_t;

    typedef struct packed {
        logic [FLOOR_W-1:0]  from_floor;
        logic [FLOOR_W-1:0]  to_floor;
        logic [TICKET_W-1:0] ticket;
    } wait_entry_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FIN,
        S_ADV_RD,
        S_ADV_MK,
        S_SCAN_INIT,
        S_SCAN,
        S_QCHK,
        S_QDAT,
        S_PICK,
        S_MARK_FROM,
        S_MARK_TO,
        S_RESOLVE,
        S_CAN_RD,
        S_CAN_CHK
    } state_t;

endpackage

### rtl/core/egd_ram.sv
`timescale 1ns / 1ps

module egd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/elevator_group_dispatcher_top.sv
`timescale 1ns / 1ps
// Sequence: a call is one scan of the mark RAM per car, then the chosen car's stops are
// marked; a queued or dropped call skips the marks. A tick serves each car's stop, moves the
// cars whose door timer has run out, then retries the queue head; a cancel checks one mark.
// Throughput: one request at a time; busy stays high from acceptance until done.
// Reset: after rst_n rises a clearing pass zeroes the stop marks, busy is high meanwhile.
// The receiver cannot stall; done marks a one-cycle result.
module elevator_group_dispatcher_top
    import egd_pkg::*;
#(
    parameter int FLOORS      = 20,
    parameter int QUEUE_SLOTS = 8,
    parameter int TICKETS     = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  req_t       request,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [4:0] cfg_data,
    output logic       done,
    output rsp_t       result
);

    `include "elevator_group_dispatcher_top_defines.svh"

    localparam int MAW = $clog2(CARS * FLOORS);
    localparam int FLW = $clog2(FLOORS);
    localparam int FCW = $clog2(FLOORS + 1);
    localparam int QAW = $clog2(QUEUE_SLOTS);
    localparam int QCW = $clog2(QUEUE_SLOTS + 1);
    localparam int QEW = $bits(wait_entry_t);

    state_t state_reg, state_next;
    logic [CAR_W-1:0]    c_reg, c_next;
    logic [FCW-1:0]      f_reg, f_next;
    logic [FLW-1:0]      fd_reg, fd_next;
    logic                pend_reg, pend_next;
    logic [FCW-1:0]      cnt_reg, cnt_next;
    logic [FCW-1:0]      below_reg, below_next;
    logic [FCW-1:0]      above_reg, above_next;
    logic [FCW-1:0]      dcnt_reg, dcnt_next;
    logic [FLOOR_W-1:0]  depart_reg, depart_next;
    logic                any_reg, any_next;
    logic [DIST_W-1:0]   best_reg, best_next;
    logic [CAR_W-1:0]    pick_reg, pick_next;
    logic                found_reg, found_next;
    logic [FLOOR_W-1:0]  a_from_reg, a_from_next;
    logic [FLOOR_W-1:0]  a_to_reg, a_to_next;
    logic [TICKET_W-1:0] a_tk_reg, a_tk_next;
    logic                retry_reg, retry_next;
    logic                asg_reg, asg_next;
    req_t                req_reg, req_next;
    rsp_t                rsp_reg, rsp_next;
    logic                done_reg, done_next;
    logic [MAW-1:0]      clr_reg, clr_next;
    logic [QAW-1:0]      head_reg, head_next;
    logic [QCW-1:0]      qcnt_reg, qcnt_next;
    logic [TICKET_W-1:0] tk_reg, tk_next;
    logic [3:0]          dwell_reg, dwell_next;
    logic [FLOOR_W-1:0]  top_reg, top_next;

    logic [FLOOR_W-1:0] floor_reg [CARS];
    logic [FLOOR_W-1:0] floor_next [CARS];
    logic [3:0]         riders_reg [CARS];
    logic [3:0]         riders_next [CARS];
    logic [3:0]         timer_reg [CARS];
    logic [3:0]         timer_next [CARS];
    logic [1:0]         dir_reg [CARS];
    logic [1:0]         dir_next [CARS];
    logic [DIST_W-1:0]  dist_reg [CARS];
    logic [DIST_W-1:0]  dist_next [CARS];

    // Stop mark RAM and wait queue RAM ports.
    logic           m_we, m_re;
    logic [MAW-1:0] m_waddr, m_raddr;
    logic [1:0]     m_wdata, m_rdata;
    logic           q_we, q_re;
    logic [QAW-1:0] q_waddr, q_raddr;
    wait_entry_t    q_wdata, q_rdata;
    logic [QEW-1:0] q_rdata_raw;

    egd_ram #(.WIDTH(2), .DEPTH(CARS * FLOORS)) u_marks (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .re    (m_re),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    egd_ram #(.WIDTH(QEW), .DEPTH(QUEUE_SLOTS)) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .re    (q_re),
        .raddr (q_raddr),
        .rdata (q_rdata_raw)
    );

    assign q_rdata = wait_entry_t'(q_rdata_raw);
    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign result  = rsp_reg;

    function automatic logic [MAW-1:0] mark_addr(input logic [CAR_W-1:0] c,
                                                 input logic [FLOOR_W-1:0] f);
        mark_addr = MAW'(int'(c) * FLOORS + int'(f));
    endfunction

    // Scan results and helpers for the current car.
    logic [FLOOR_W-1:0] cur;
    logic [1:0]         dir_w;
    logic [DIST_W-1:0]  dist_w;
    logic [FLOOR_W-1:0] absdiff;
    logic [CARS-1:0]    zone_allow;
    logic [QCW:0]       tail_sum;
    logic [QAW-1:0]     tail;
    logic               lowb, highb;

    assign cur = floor_reg[c_reg];

    always_comb
    begin
        if (cnt_reg == '0)
            dir_w = DIR_NONE;
        else if (cur != depart_reg)
            dir_w = (cur < depart_reg) ? DIR_UP : DIR_DOWN;
        else if (below_reg > above_reg)
            dir_w = DIR_DOWN;
        else if (below_reg < above_reg)
            dir_w = DIR_UP;
        else
            dir_w = DIR_NONE;
    end

    assign absdiff = (cur < a_from_reg) ? (a_from_reg - cur) : (cur - a_from_reg);
    assign dist_w  = DIST_W'(absdiff) + DIST_W'(dcnt_reg);

    // Zone rule for the request under assignment.
    assign lowb  = (a_from_reg <= top_reg) && (a_to_reg <= top_reg);
    assign highb = ((a_from_reg > top_reg) && (a_to_reg > top_reg)) ||
                   ((a_from_reg > top_reg) && (a_to_reg == '0)) ||
                   ((a_from_reg == '0) && (a_to_reg > top_reg));
    assign zone_allow = lowb ? ZONE_LOW : (highb ? ZONE_HIGH : ZONE_CROSS);

    // Queue tail slot.
    always_comb
    begin
        tail_sum = (QCW+1)'(head_reg) + (QCW+1)'(qcnt_reg);
        if (tail_sum >= (QCW+1)'(QUEUE_SLOTS))
            tail_sum = tail_sum - (QCW+1)'(QUEUE_SLOTS);
        tail = tail_sum[QAW-1:0];
    end

    // Sequencer: next state, RAM accesses and state updates.
    always_comb
    begin
        logic [1:0]  mk;
        logic [3:0]  r;
        logic [3:0]  t;
        logic        ok;
        logic        in_range;
        logic        fnd;
        logic [1:0]  dc;
        logic [FLOOR_W-1:0] fl;

        state_next  = state_reg;
        c_next      = c_reg;
        f_next      = f_reg;
        fd_next     = fd_reg;
        pend_next   = pend_reg;
        cnt_next    = cnt_reg;
        below_next  = below_reg;
        above_next  = above_reg;
        dcnt_next   = dcnt_reg;
        depart_next = depart_reg;
        any_next    = any_reg;
        best_next   = best_reg;
        pick_next   = pick_reg;
        found_next  = found_reg;
        a_from_next = a_from_reg;
        a_to_next   = a_to_reg;
        a_tk_next   = a_tk_reg;
        retry_next  = retry_reg;
        asg_next    = asg_reg;
        req_next    = req_reg;
        rsp_next    = rsp_reg;
        done_next   = 1'b0;
        clr_next    = clr_reg;
        head_next   = head_reg;
        qcnt_next   = qcnt_reg;
        tk_next     = tk_reg;
        dwell_next  = dwell_reg;
        top_next    = top_reg;
        floor_next  = floor_reg;
        riders_next = riders_reg;
        timer_next  = timer_reg;
        dir_next    = dir_reg;
        dist_next   = dist_reg;

        m_we    = 1'b0;
        m_waddr = '0;
        m_wdata = MARK_NONE;
        m_re    = 1'b0;
        m_raddr = '0;
        q_we    = 1'b0;
        q_waddr = '0;
        q_wdata = '0;
        q_re    = 1'b0;
        q_raddr = '0;

        mk       = MARK_NONE;
        r        = '0;
        t        = '0;
        ok       = 1'b0;
        in_range = 1'b0;
        fnd      = 1'b0;
        dc       = DIR_NONE;
        fl       = '0;

        // Configuration writes.
        if (cfg_we)
        begin
            if (cfg_index == CFG_DOOR_DWELL)
                dwell_next = cfg_data[3:0];
            else
                top_next = cfg_data;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                m_we    = 1'b1;
                m_waddr = clr_reg;
                m_wdata = MARK_NONE;
                if (clr_reg == MAW'(CARS * FLOORS - 1))
                    state_next = S_IDLE;
                else
                    clr_next = clr_reg + 1'b1;
            end

            S_IDLE:
            begin
                if (start)
                begin
                    req_next = request;
                    rsp_next = '0;
                    c_next   = '0;
                    priority if (request.op == OP_TICK)
                    begin
                        state_next = S_ADV_RD;
                    end
                    else if (request.op == OP_CALL)
                    begin
                        if ((int'(request.from_floor) < FLOORS) &&
                            (int'(request.to_floor) < FLOORS) &&
                            (request.from_floor != request.to_floor))
                        begin
                            a_from_next = request.from_floor;
                            a_to_next   = request.to_floor;
                            retry_next  = 1'b0;
                            asg_next    = 1'b1;
                            any_next    = 1'b0;
                            state_next  = S_SCAN_INIT;
                        end
                        else
                        begin
                            rsp_next.status = ST_INVALID;
                            state_next      = S_FIN;
                        end
                    end
                    else if (request.op == OP_CANCEL)
                    begin
                        if ((int'(request.car) < CARS) && (int'(request.to_floor) < FLOORS))
                        begin
                            state_next = S_CAN_RD;
                        end
                        else
                        begin
                            rsp_next.status = ST_INVALID;
                            state_next      = S_FIN;
                        end
                    end
                    else
                    begin
                        rsp_next.status = ST_INVALID;
                        state_next      = S_FIN;
                    end
                end
            end

            S_FIN:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            // Read the mark at the car's floor.
            S_ADV_RD:
            begin
                m_re       = 1'b1;
                m_raddr    = mark_addr(c_reg, cur);
                state_next = S_ADV_MK;
            end

            // Serve the stop, then move or count the door down.
            S_ADV_MK:
            begin
                mk = m_rdata;
                r  = riders_reg[c_reg];
                t  = timer_reg[c_reg];
                if (mk != MARK_NONE)
                begin
                    if ((mk == MARK_PICKUP) && (r < RIDER_MAX))
                        r = r + 1'b1;
                    if (r != '0)
                    begin
                        m_we    = 1'b1;
                        m_waddr = mark_addr(c_reg, cur);
                        m_wdata = MARK_NONE;
                        t       = dwell_reg;
                    end
                end
                riders_next[c_reg] = r;
                if (t == '0)
                begin
                    timer_next[c_reg] = t;
                    asg_next          = 1'b0;
                    state_next        = S_SCAN_INIT;
                end
                else
                begin
                    timer_next[c_reg] = t - 1'b1;
                    if (int'(c_reg) == CARS - 1)
                        state_next = S_QCHK;
                    else
                    begin
                        c_next     = c_reg + 1'b1;
                        state_next = S_ADV_RD;
                    end
                end
            end

            S_SCAN_INIT:
            begin
                f_next      = '0;
                pend_next   = 1'b0;
                cnt_next    = '0;
                below_next  = '0;
                above_next  = '0;
                dcnt_next   = '0;
                depart_next = cur;
                state_next  = S_SCAN;
            end

            // Walk every floor of the car; read data comes back in the cycle after its address.
            S_SCAN:
            begin
                if (pend_reg && (m_rdata != MARK_NONE))
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (m_rdata == MARK_PICKUP)
                        depart_next = FLOOR_W'(fd_reg);
                    if (int'(fd_reg) < int'(cur))
                        below_next = below_reg + 1'b1;
                    else if (int'(fd_reg) > int'(cur))
                        above_next = above_reg + 1'b1;
                    if (cur < a_from_reg)
                        in_range = (int'(fd_reg) >= int'(cur)) &&
                                   (int'(fd_reg) < int'(a_from_reg));
                    else
                        in_range = (int'(fd_reg) > int'(a_from_reg)) &&
                                   (int'(fd_reg) <= int'(cur));
                    if (in_range)
                        dcnt_next = dcnt_reg + 1'b1;
                end
                if (f_reg < FCW'(FLOORS))
                begin
                    m_re      = 1'b1;
                    m_raddr   = mark_addr(c_reg, FLOOR_W'(f_reg[FLW-1:0]));
                    fd_next   = f_reg[FLW-1:0];
                    pend_next = 1'b1;
                    f_next    = f_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (!asg_reg)
                        begin
                            if (dir_w == DIR_UP)
                            begin
                                if (int'(cur) < FLOORS - 1)
                                    floor_next[c_reg] = cur + 1'b1;
                            end
                            else if (dir_w == DIR_DOWN)
                            begin
                                if (cur != '0)
                                    floor_next[c_reg] = cur - 1'b1;
                            end
                            else
                            begin
                                riders_next[c_reg] = '0;
                            end
                            if (int'(c_reg) == CARS - 1)
                                state_next = S_QCHK;
                            else
                            begin
                                c_next     = c_reg + 1'b1;
                                state_next = S_ADV_RD;
                            end
                        end
                        else
                        begin
                            dir_next[c_reg]  = dir_w;
                            dist_next[c_reg] = dist_w;
                            any_next         = any_reg | (cnt_reg != '0);
                            if (int'(c_reg) == CARS - 1)
                            begin
                                c_next     = '0;
                                best_next  = DIST_INIT;
                                found_next = 1'b0;
                                state_next = S_PICK;
                            end
                            else
                            begin
                                c_next     = c_reg + 1'b1;
                                state_next = S_SCAN_INIT;
                            end
                        end
                    end
                end
            end

            // Retry the oldest waiting request, if any.
            S_QCHK:
            begin
                if (qcnt_reg == '0)
                begin
                    rsp_next.status = ST_TICK_IDLE;
                    state_next      = S_FIN;
                end
                else
                begin
                    q_re       = 1'b1;
                    q_raddr    = head_reg;
                    state_next = S_QDAT;
                end
            end

            S_QDAT:
            begin
                a_from_next = q_rdata.from_floor;
                a_to_next   = q_rdata.to_floor;
                a_tk_next   = q_rdata.ticket;
                head_next   = (int'(head_reg) == QUEUE_SLOTS - 1) ? '0 : head_reg + 1'b1;
                qcnt_next   = qcnt_reg - 1'b1;
                retry_next  = 1'b1;
                asg_next    = 1'b1;
                any_next    = 1'b0;
                c_next      = '0;
                state_next  = S_SCAN_INIT;
            end

            // Pick the eligible car with the least distance, lowest number on ties.
            S_PICK:
            begin
                dc = dir_reg[c_reg];
                fl = floor_reg[c_reg];
                ok = !any_reg || (dc == DIR_NONE) ||
                     ((a_to_reg > a_from_reg) && (dc == DIR_UP) && (fl <= a_from_reg)) ||
                     ((a_to_reg < a_from_reg) && (dc == DIR_DOWN) && (fl >= a_from_reg));
                ok  = ok && zone_allow[c_reg];
                fnd = found_reg;
                if (ok && (dist_reg[c_reg] < best_reg))
                begin
                    best_next = dist_reg[c_reg];
                    pick_next = c_reg;
                    fnd       = 1'b1;
                end
                found_next = fnd;
                if (int'(c_reg) == CARS - 1)
                    state_next = fnd ? S_MARK_FROM : S_RESOLVE;
                else
                    c_next = c_reg + 1'b1;
            end

            S_MARK_FROM:
            begin
                m_we       = 1'b1;
                m_waddr    = mark_addr(pick_reg, a_from_reg);
                m_wdata    = MARK_PICKUP;
                state_next = S_MARK_TO;
            end

            S_MARK_TO:
            begin
                m_we       = 1'b1;
                m_waddr    = mark_addr(pick_reg, a_to_reg);
                m_wdata    = MARK_DEST;
                state_next = S_RESOLVE;
            end

            // Form the result; queue the request when no car took it, or drop a new call when the queue is full.
            S_RESOLVE:
            begin
                rsp_next.out_from = a_from_reg;
                rsp_next.out_to   = a_to_reg;
                if (found_reg)
                begin
                    rsp_next.status       = retry_reg ? ST_FROM_QUEUE : ST_ASSIGNED;
                    rsp_next.assigned_car = pick_reg;
                    rsp_next.wait_number  = retry_reg ? a_tk_reg : '0;
                end
                else if (retry_reg)
                begin
                    q_we    = 1'b1;
                    q_waddr = tail;
                    q_wdata = '{from_floor: a_from_reg, to_floor: a_to_reg, ticket: a_tk_reg};
                    qcnt_next            = qcnt_reg + 1'b1;
                    rsp_next.status      = ST_QUEUED;
                    rsp_next.wait_number = a_tk_reg;
                end
                else if (qcnt_reg >= QCW'(QUEUE_SLOTS))
                begin
                    rsp_next.status = ST_DROPPED;
                end
                else
                begin
                    q_we    = 1'b1;
                    q_waddr = tail;
                    q_wdata = '{from_floor: a_from_reg, to_floor: a_to_reg, ticket: tk_reg};
                    qcnt_next            = qcnt_reg + 1'b1;
                    rsp_next.status      = ST_QUEUED;
                    rsp_next.wait_number = tk_reg;
                    tk_next = (int'(tk_reg) + 1 >= TICKETS) ? '0 : tk_reg + 1'b1;
                end
                state_next = S_FIN;
            end

            S_CAN_RD:
            begin
                m_re       = 1'b1;
                m_raddr    = mark_addr(req_reg.car, req_reg.to_floor);
                state_next = S_CAN_CHK;
            end

            S_CAN_CHK:
            begin
                rsp_next.assigned_car = req_reg.car;
                rsp_next.out_to       = req_reg.to_floor;
                if (m_rdata == MARK_DEST)
                begin
                    m_we            = 1'b1;
                    m_waddr         = mark_addr(req_reg.car, req_reg.to_floor);
                    m_wdata         = MARK_NONE;
                    rsp_next.status = ST_CANCELLED;
                end
                else
                begin
                    rsp_next.status = ST_NOT_FOUND;
                end
                state_next = S_FIN;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            c_reg      <= '0;
            f_reg      <= '0;
            fd_reg     <= '0;
            pend_reg   <= 1'b0;
            cnt_reg    <= '0;
            below_reg  <= '0;
            above_reg  <= '0;
            dcnt_reg   <= '0;
            depart_reg <= '0;
            any_reg    <= 1'b0;
            best_reg   <= DIST_INIT;
            pick_reg   <= '0;
            found_reg  <= 1'b0;
            a_from_reg <= '0;
            a_to_reg   <= '0;
            a_tk_reg   <= '0;
            retry_reg  <= 1'b0;
            asg_reg    <= 1'b0;
            req_reg    <= '0;
            rsp_reg    <= '0;
            done_reg   <= 1'b0;
            clr_reg    <= '0;
            head_reg   <= '0;
            qcnt_reg   <= '0;
            tk_reg     <= '0;
            dwell_reg  <= 4'd2;
            top_reg    <= 5'd9;
            for (int i = 0; i < CARS; i++)
            begin
                floor_reg[i]  <= '0;
                riders_reg[i] <= '0;
                timer_reg[i]  <= '0;
                dir_reg[i]    <= DIR_NONE;
                dist_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            c_reg       <= c_next;
            f_reg       <= f_next;
            fd_reg      <= fd_next;
            pend_reg    <= pend_next;
            cnt_reg     <= cnt_next;
            below_reg   <= below_next;
            above_reg   <= above_next;
            dcnt_reg    <= dcnt_next;
            depart_reg  <= depart_next;
            any_reg     <= any_next;
            best_reg    <= best_next;
            pick_reg    <= pick_next;
            found_reg   <= found_next;
            a_from_reg  <= a_from_next;
            a_to_reg    <= a_to_next;
            a_tk_reg    <= a_tk_next;
            retry_reg   <= retry_next;
            asg_reg     <= asg_next;
            req_reg     <= req_next;
            rsp_reg     <= rsp_next;
            done_reg    <= done_next;
            clr_reg     <= clr_next;
            head_reg    <= head_next;
            qcnt_reg    <= qcnt_next;
            tk_reg      <= tk_next;
            dwell_reg   <= dwell_next;
            top_reg     <= top_next;
            floor_reg   <= floor_next;
            riders_reg  <= riders_next;
            timer_reg   <= timer_next;
            dir_reg     <= dir_next;
            dist_reg    <= dist_next;
        end
    end

    // A result only appears once the block has gone idle again.
    `EGD_ASSERT_ALWAYS(a_done_idle, !done || !busy)
    // Every accepted request makes the block busy in the following cycle.
    `EGD_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    // The waiting queue never holds more than its slots.
    `EGD_ASSERT_ALWAYS(a_queue_bound, qcnt_reg <= QCW'(QUEUE_SLOTS))
    // Ticket numbers stay inside their range.
    `EGD_ASSERT_ALWAYS(a_ticket_range, int'(tk_reg) < TICKETS)

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import egd_pkg::*;

    localparam int NFLOORS = 20;
    localparam int NSLOTS  = 8;
    localparam int NTICKETS = 10;
    localparam int NRANDOM = 400;
    localparam int REQ_W = $bits(req_t);

    // Operation code that the block does not define.
    localparam logic [1:0] OP_RESERVED = 2'd3;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t request;
    logic cfg_we;
    logic cfg_index;
    logic [4:0] cfg_data;
    logic done;
    rsp_t result;

    elevator_group_dispatcher_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .result(result)
    );

    // Dispatcher shadow state.
    int unsigned car_pos [CARS];
    logic [1:0]  marks [CARS][NFLOORS];
    int unsigned load [CARS];
    int unsigned door [CARS];
    int unsigned wq_from [NSLOTS];
    int unsigned wq_to [NSLOTS];
    int unsigned wq_tkt [NSLOTS];
    int unsigned q_head, q_count, ticket_next;
    int unsigned dwell, zone_top;

    rsp_t expected_rsp [$];
    int errors;
    logic use_typed;
    rsp_t typed_rsp;
    int send_idle_pct;

    typedef struct {
        logic [1:0] op;
        logic [4:0] from_floor;
        logic [4:0] to_floor;
        logic [2:0] car;
        logic       typed;
        rsp_t       rsp;
    } stim_row_t;

    stim_row_t rows [$];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("** elevator_group_dispatcher_top: FAILED **");
        $finish;
    end

    // Direction a car wants to go: toward its pickup, else toward most marks.
    function automatic logic [1:0] travel_dir(int c);
        int unsigned depart, cnt, below, above;
        depart = car_pos[c];
        cnt = 0;
        below = 0;
        above = 0;
        for (int f = 0; f < NFLOORS; f++)
        begin
            if (marks[c][f] != MARK_NONE)
            begin
                cnt++;
                if (marks[c][f] == MARK_PICKUP)
                    depart = f;
                if (f < car_pos[c])
                    below++;
                else if (f > car_pos[c])
                    above++;
            end
        end
        if (cnt == 0)
            return DIR_NONE;
        if (car_pos[c] != depart)
            return (car_pos[c] < depart) ? DIR_UP : DIR_DOWN;
        if (below > above)
            return DIR_DOWN;
        if (below < above)
            return DIR_UP;
        return DIR_NONE;
    endfunction

    // Floors to travel plus marked floors passed on the way.
    function automatic int unsigned pickup_distance(int c, int unsigned from_f);
        int unsigned d;
        int cur;
        cur = car_pos[c];
        if (cur < from_f)
        begin
            d = from_f - cur;
            for (int f = cur; f < from_f; f++)
                if (marks[c][f] != MARK_NONE)
                    d++;
        end
        else
        begin
            d = cur - from_f;
            for (int f = cur; f > int'(from_f); f--)
                if (f < NFLOORS && marks[c][f] != MARK_NONE)
                    d++;
        end
        return d;
    endfunction

    // Choose the nearest eligible car and mark its stops; -1 when none.
    function automatic int pick_car(int unsigned from_f, int unsigned to_f);
        logic ok [CARS];
        logic any_mark;
        logic [1:0] d;
        int pick;
        int unsigned best, cost;
        any_mark = 1'b0;
        for (int c = 0; c < CARS; c++)
            for (int f = 0; f < NFLOORS; f++)
                if (marks[c][f] != MARK_NONE)
                    any_mark = 1'b1;
        for (int c = 0; c < CARS; c++)
        begin
            if (!any_mark)
                ok[c] = 1'b1;
            else
            begin
                d = travel_dir(c);
                ok[c] = (d == DIR_NONE);
                if (to_f > from_f && d == DIR_UP && car_pos[c] <= from_f)
                    ok[c] = 1'b1;
                if (to_f < from_f && d == DIR_DOWN && car_pos[c] >= from_f)
                    ok[c] = 1'b1;
            end
        end
        if (from_f <= zone_top && to_f <= zone_top)
        begin
            ok[2] = 1'b0;
            ok[3] = 1'b0;
        end
        else if ((from_f > zone_top && to_f > zone_top) || (from_f > zone_top && to_f == 0)
                 || (from_f == 0 && to_f > zone_top))
        begin
            ok[0] = 1'b0;
            ok[1] = 1'b0;
        end
        else
        begin
            for (int c = 0; c < 4; c++)
                ok[c] = 1'b0;
        end
        pick = -1;
        best = 100;
        for (int c = 0; c < CARS; c++)
        begin
            if (ok[c])
            begin
                cost = pickup_distance(c, from_f);
                if (cost < best)
                begin
                    best = cost;
                    pick = c;
                end
            end
        end
        if (pick >= 0)
        begin
            marks[pick][from_f] = MARK_PICKUP;
            marks[pick][to_f] = MARK_DEST;
        end
        return pick;
    endfunction

    function automatic void queue_push(int unsigned f, int unsigned t, int unsigned tk);
        int unsigned tail;
        tail = (q_head + q_count) % NSLOTS;
        wq_from[tail] = f;
        wq_to[tail] = t;
        wq_tkt[tail] = tk;
        q_count++;
    endfunction

    // One tick of car motion and door handling.
    function automatic void move_cars();
        int unsigned cur;
        logic [1:0] d;
        for (int c = 0; c < CARS; c++)
        begin
            cur = car_pos[c];
            if (marks[c][cur] != MARK_NONE)
            begin
                if (marks[c][cur] == MARK_PICKUP && load[c] < 15)
                    load[c]++;
                if (load[c] > 0)
                begin
                    marks[c][cur] = MARK_NONE;
                    door[c] = dwell;
                end
            end
            if (door[c] == 0)
            begin
                d = travel_dir(c);
                if (d == DIR_UP)
                begin
                    if (car_pos[c] < NFLOORS - 1)
                        car_pos[c]++;
                end
                else if (d == DIR_DOWN)
                begin
                    if (car_pos[c] > 0)
                        car_pos[c]--;
                end
                else
                    load[c] = 0;
            end
            else
                door[c]--;
        end
    endfunction

    // Expected response to one request; updates the shadow state.
    function automatic rsp_t dispatch(req_t r);
        rsp_t o;
        int c;
        int unsigned wf, wt, wk;
        o = '0;
        o.status = ST_INVALID;
        if (r.op == OP_TICK)
        begin
            move_cars();
            if (q_count == 0)
                o.status = ST_TICK_IDLE;
            else
            begin
                wf = wq_from[q_head];
                wt = wq_to[q_head];
                wk = wq_tkt[q_head];
                q_head = (q_head + 1) % NSLOTS;
                q_count--;
                c = pick_car(wf, wt);
                if (c >= 0)
                begin
                    o.status = ST_FROM_QUEUE;
                    o.assigned_car = CAR_W'(c);
                end
                else
                begin
                    o.status = ST_QUEUED;
                    queue_push(wf, wt, wk);
                end
                o.wait_number = TICKET_W'(wk);
                o.out_from = FLOOR_W'(wf);
                o.out_to = FLOOR_W'(wt);
            end
        end
        else if (r.op == OP_CALL)
        begin
            if (r.from_floor < NFLOORS && r.to_floor < NFLOORS && r.from_floor != r.to_floor)
            begin
                c = pick_car(r.from_floor, r.to_floor);
                o.out_from = r.from_floor;
                o.out_to = r.to_floor;
                if (c >= 0)
                begin
                    o.status = ST_ASSIGNED;
                    o.assigned_car = CAR_W'(c);
                end
                else if (q_count >= NSLOTS)
                    o.status = ST_DROPPED;
                else
                begin
                    o.status = ST_QUEUED;
                    o.wait_number = TICKET_W'(ticket_next);
                    queue_push(r.from_floor, r.to_floor, ticket_next);
                    ticket_next = (ticket_next + 1 >= NTICKETS) ? 0 : ticket_next + 1;
                end
            end
        end
        else if (r.op == OP_CANCEL)
        begin
            if (r.car < CARS && r.to_floor < NFLOORS)
            begin
                o.assigned_car = r.car;
                o.out_to = r.to_floor;
                if (marks[r.car][r.to_floor] == MARK_DEST)
                begin
                    marks[r.car][r.to_floor] = MARK_NONE;
                    o.status = ST_CANCELLED;
                end
                else
                    o.status = ST_NOT_FOUND;
            end
        end
        return o;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
        errors++;
    endtask

    // Predict on each accepted request; check each completed one.
    always @(posedge clk)
    begin
        rsp_t pred;
        rsp_t want;
        if (rst_n && start && !busy)
        begin
            pred = dispatch(request);
            expected_rsp.push_back(use_typed ? typed_rsp : pred);
        end
        if (rst_n && done)
        begin
            if (expected_rsp.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (result.status !== want.status)
                    report_mismatch("status", result.status, want.status);
                if (result.assigned_car !== want.assigned_car)
                    report_mismatch("assigned_car", result.assigned_car, want.assigned_car);
                if (result.wait_number !== want.wait_number)
                    report_mismatch("wait_number", result.wait_number, want.wait_number);
                if (result.out_from !== want.out_from)
                    report_mismatch("out_from", result.out_from, want.out_from);
                if (result.out_to !== want.out_to)
                    report_mismatch("out_to", result.out_to, want.out_to);
            end
        end
    end

    // Present one request and hold it until the block takes it.
    task automatic send_request(req_t r, logic typed, rsp_t t);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        request = r;
        use_typed = typed;
        typed_rsp = t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (expected_rsp.size() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [4:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        if (idx == CFG_DOOR_DWELL)
            dwell = val & 5'h0f;
        else
            zone_top = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic req_t random_request();
        req_t r;
        int unsigned pick;
        r = req_t'(REQ_W'($urandom));
        pick = $urandom_range(99);
        if (pick < 3)
            r.op = OP_RESERVED;
        else if (pick < 33)
            r.op = OP_TICK;
        else if (pick < 45)
            r.op = OP_CANCEL;
        else
            r.op = OP_CALL;
        if ($urandom_range(9) != 0)
        begin
            r.from_floor = FLOOR_W'($urandom_range(NFLOORS - 1));
            r.to_floor = FLOOR_W'($urandom_range(NFLOORS - 1));
        end
        if (r.op == OP_CANCEL && $urandom_range(7) != 0)
            r.car = CAR_W'($urandom_range(CARS - 1));
        return r;
    endfunction

    function automatic stim_row_t row(logic [1:0] op, int f, int t, int c,
                                      logic typed, rsp_t r);
        stim_row_t s;
        s.op = op;
        s.from_floor = 5'(f);
        s.to_floor = 5'(t);
        s.car = 3'(c);
        s.typed = typed;
        s.rsp = r;
        return s;
    endfunction

    function automatic rsp_t mk(logic [2:0] st, int c, int w, int f, int t);
        rsp_t r;
        r.status = st;
        r.assigned_car = CAR_W'(c);
        r.wait_number = TICKET_W'(w);
        r.out_from = FLOOR_W'(f);
        r.out_to = FLOOR_W'(t);
        return r;
    endfunction

    initial
    begin
        req_t r;
        errors = 0;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_DOOR_DWELL;
        cfg_data = '0;
        use_typed = 1'b0;
        typed_rsp = '0;
        send_idle_pct = 38;
        for (int c = 0; c < CARS; c++)
        begin
            car_pos[c] = 0;
            load[c] = 0;
            door[c] = 0;
            for (int f = 0; f < NFLOORS; f++)
                marks[c][f] = MARK_NONE;
        end
        q_head = 0;
        q_count = 0;
        ticket_next = 0;
        dwell = 2;
        zone_top = 9;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed requests: empty tick, assign and cancel, invalid forms, extremes.
        rows.push_back(row(OP_TICK, 0, 0, 0, 1'b1, mk(ST_TICK_IDLE, 0, 0, 0, 0)));
        rows.push_back(row(OP_CALL, 0, 5, 0, 1'b1, mk(ST_ASSIGNED, 0, 0, 0, 5)));
        rows.push_back(row(OP_CANCEL, 0, 5, 0, 1'b1, mk(ST_CANCELLED, 0, 0, 0, 5)));
        rows.push_back(row(OP_CANCEL, 0, 5, 0, 1'b1, mk(ST_NOT_FOUND, 0, 0, 0, 5)));
        rows.push_back(row(OP_RESERVED, 31, 31, 7, 1'b1, mk(ST_INVALID, 0, 0, 0, 0)));
        rows.push_back(row(OP_CALL, 31, 4, 0, 1'b1, mk(ST_INVALID, 0, 0, 0, 0)));
        rows.push_back(row(OP_CALL, 4, 31, 0, 1'b1, mk(ST_INVALID, 0, 0, 0, 0)));
        rows.push_back(row(OP_CALL, 7, 7, 0, 1'b1, mk(ST_INVALID, 0, 0, 0, 0)));
        rows.push_back(row(OP_CANCEL, 0, 3, 7, 1'b1, mk(ST_INVALID, 0, 0, 0, 0)));
        rows.push_back(row(OP_CANCEL, 0, 0, 6, 1'b1, mk(ST_INVALID, 0, 0, 0, 0)));
        rows.push_back(row(OP_CANCEL, 0, 20, 2, 1'b1, mk(ST_INVALID, 0, 0, 0, 0)));
        rows.push_back(row(OP_CALL, 0, 19, 0, 1'b0, '0));
        rows.push_back(row(OP_CALL, 19, 0, 0, 1'b0, '0));
        rows.push_back(row(OP_CALL, 9, 10, 0, 1'b0, '0));
        rows.push_back(row(OP_CALL, 10, 9, 0, 1'b0, '0));
        rows.push_back(row(OP_CALL, 1, 18, 0, 1'b0, '0));
        rows.push_back(row(OP_CALL, 18, 2, 0, 1'b0, '0));
        rows.push_back(row(OP_TICK, 0, 0, 0, 1'b0, '0));
        rows.push_back(row(OP_TICK, 0, 0, 0, 1'b0, '0));
        rows.push_back(row(OP_CANCEL, 0, 19, 5, 1'b0, '0));
        rows.push_back(row(OP_TICK, 0, 0, 0, 1'b0, '0));
        rows.push_back(row(OP_TICK, 0, 0, 0, 1'b0, '0));

        // Wait out the clearing pass before the first register write.
        wait_idle();
        write_reg(CFG_DOOR_DWELL, 5'd2);
        write_reg(CFG_LOW_ZONE_TOP, 5'd9);
        foreach (rows[i])
        begin
            r.op = rows[i].op;
            r.from_floor = rows[i].from_floor;
            r.to_floor = rows[i].to_floor;
            r.car = rows[i].car;
            send_request(r, rows[i].typed, rows[i].rsp);
        end

        // Random phases, each under its own register setting and sender pacing.
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_idle();
            unique case (ph)
                0:
                begin
                    write_reg(CFG_DOOR_DWELL, 5'd0);
                    write_reg(CFG_LOW_ZONE_TOP, 5'd1);
                    send_idle_pct = 38;
                end
                1:
                begin
                    write_reg(CFG_DOOR_DWELL, 5'd15);
                    write_reg(CFG_LOW_ZONE_TOP, 5'd18);
                    send_idle_pct = 73;
                end
                2:
                begin
                    write_reg(CFG_DOOR_DWELL, 5'($urandom_range(15)));
                    write_reg(CFG_LOW_ZONE_TOP, 5'($urandom_range(18, 1)));
                    send_idle_pct = 0;
                end
                default:
                begin
                    write_reg(CFG_DOOR_DWELL, 5'd1);
                    write_reg(CFG_LOW_ZONE_TOP, 5'd9);
                    send_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < NRANDOM / 4; n++)
                send_request(random_request(), 1'b0, '0);
        end

        @(negedge clk);
        start = 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("** elevator_group_dispatcher_top: PASSED **");
        else
            $display("** elevator_group_dispatcher_top: FAILED **");
        $finish;
    end

endmodule
